FILE: rtl/core/pqs_pkg.sv
// ----------------------------------------------------------------------------
// pqs_pkg
// Shared types and constants for the patch quantile select block.
// ----------------------------------------------------------------------------
package pqs_pkg;

  // default store depth
  localparam int PQS_MAX_SAMPLES = 64;

  // field widths
  localparam int PQS_SAMPLE_W = 16;
  localparam int PQS_FRAC_W   = 17;
  localparam int PQS_COUNT_W  = 7;

  // fraction of one in units of 1/65536
  localparam logic [PQS_FRAC_W-1:0] PQS_FRAC_ONE  = 17'h10000;
  localparam logic [PQS_FRAC_W-1:0] PQS_QF_RESET  = 17'h08000;

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_POS,
    ST_CAPT,
    ST_SCAN,
    ST_DONE
  } pqs_state_t;

  // selected order statistics handed to the interpolator
  typedef struct packed {
    logic signed [PQS_SAMPLE_W-1:0] lo;
    logic signed [PQS_SAMPLE_W-1:0] hi;
    logic        [15:0]             frac;
    logic                           need_hi;
    logic        [PQS_COUNT_W-1:0]  count;
  } pqs_sel_t;

endpackage

FILE: rtl/core/pqs_in_if.sv
// ----------------------------------------------------------------------------
// pqs_in_if
// Sample input channel: valid/ready with sample and last marker.
// ----------------------------------------------------------------------------
interface pqs_in_if
  import pqs_pkg::*;
  ();
  logic                           valid;
  logic                           ready;
  logic signed [PQS_SAMPLE_W-1:0] sample;
  logic                           last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

FILE: rtl/core/pqs_out_if.sv
// ----------------------------------------------------------------------------
// pqs_out_if
// Result output channel: valid/ready with quantile value and sample count.
// ----------------------------------------------------------------------------
interface pqs_out_if
  import pqs_pkg::*;
  ();
  logic                           valid;
  logic                           ready;
  logic signed [PQS_SAMPLE_W-1:0] quantile_value;
  logic        [PQS_COUNT_W-1:0]  sample_count;

  modport source (output valid, output quantile_value, output sample_count, input ready);
  modport sink   (input valid, input quantile_value, input sample_count, output ready);
endinterface

FILE: rtl/core/pqs_ram.sv
// ----------------------------------------------------------------------------
// pqs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pqs_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/pqs_ctrl.sv
// ----------------------------------------------------------------------------
// pqs_ctrl
// Loads samples into the store, then finds the two order statistics around
// the quantile position by rank counting over the store.
// ----------------------------------------------------------------------------
module pqs_ctrl
  import pqs_pkg::*;
#(
  parameter  int MAX_SAMPLES = PQS_MAX_SAMPLES,
  localparam int AW          = $clog2(MAX_SAMPLES)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic        [PQS_FRAC_W-1:0]   quantile_fraction,
  pqs_in_if.sink                         sample_in,
  output logic                           ram_we,
  output logic        [AW-1:0]           ram_waddr,
  output logic        [PQS_SAMPLE_W-1:0] ram_wdata,
  output logic        [AW-1:0]           ram_raddr,
  input  logic        [PQS_SAMPLE_W-1:0] ram_rdata,
  output logic                           sel_valid,
  input  logic                           sel_ready,
  output pqs_sel_t                       sel
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int PW = PQS_FRAC_W + CW;
  localparam int XW = (CW > PQS_COUNT_W) ? CW : PQS_COUNT_W;

  pqs_state_t state, state_next;

  logic        [CW-1:0]           count;
  logic        [CW-1:0]           n;
  logic        [PW-1:0]           pos;
  logic        [CW-1:0]           i;
  logic        [CW-1:0]           jd;
  logic        [CW-1:0]           rank;
  logic signed [PQS_SAMPLE_W-1:0] cand;
  logic signed [PQS_SAMPLE_W-1:0] lo;
  logic signed [PQS_SAMPLE_W-1:0] hi;

  logic                           accept;
  logic                           has_room;
  logic        [CW-1:0]           count_upd;
  logic        [PQS_FRAC_W-1:0]   q_sat;
  logic        [CW-1:0]           idx;
  logic        [15:0]             frac;
  logic signed [PQS_SAMPLE_W-1:0] rd_val;
  logic                           hit;
  logic        [CW-1:0]           rank_fin;
  logic                           scan_last;
  logic                           cand_last;
  logic        [XW-1:0]           n_ext;

  // load side
  assign accept    = sample_in.valid && sample_in.ready;
  assign has_room  = count < CW'(MAX_SAMPLES);
  assign count_upd = count + CW'(has_room);
  assign ram_we    = accept && has_room;
  assign ram_waddr = count[AW-1:0];
  assign ram_wdata = sample_in.sample;

  // quantile position split into rank and blend weight
  assign q_sat = (quantile_fraction > PQS_FRAC_ONE) ? PQS_FRAC_ONE : quantile_fraction;
  assign idx   = pos[16 +: CW];
  assign frac  = pos[15:0];

  // rank test: smaller value, or equal value stored earlier
  assign rd_val    = $signed(ram_rdata);
  assign hit       = (rd_val < cand) || ((rd_val == cand) && (jd < i));
  assign rank_fin  = rank + CW'(hit);
  assign scan_last = (jd == n - CW'(1));
  assign cand_last = (i == n - CW'(1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: if (accept && sample_in.last) state_next = ST_POS;
      ST_POS:  state_next = ST_CAPT;
      ST_CAPT: state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_last) begin
          state_next = cand_last ? ST_DONE : ST_CAPT;
        end
      end
      ST_DONE: if (sel_ready) state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    sample_in.ready = 1'b0;
    sel_valid       = 1'b0;
    ram_raddr       = '0;
    unique case (state)
      ST_LOAD: sample_in.ready = 1'b1;
      ST_POS:  ram_raddr = '0;
      ST_CAPT: ram_raddr = '0;
      ST_SCAN: ram_raddr = scan_last ? AW'(i + CW'(1)) : AW'(jd + CW'(1));
      ST_DONE: sel_valid = 1'b1;
      default: ram_raddr = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      i     <= '0;
      jd    <= '0;
      rank  <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            count <= sample_in.last ? '0 : count_upd;
          end
        end
        ST_POS: i <= '0;
        ST_CAPT: begin
          jd   <= '0;
          rank <= '0;
        end
        ST_SCAN: begin
          if (scan_last) begin
            i <= i + CW'(1);
          end else begin
            rank <= rank_fin;
            jd   <= jd + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_LOAD && accept && sample_in.last) begin
      n <= count_upd;
    end
    if (state == ST_POS) begin
      pos <= PW'(q_sat) * PW'(n - CW'(1));
    end
    if (state == ST_CAPT) begin
      cand <= rd_val;
    end
    if (state == ST_SCAN && scan_last) begin
      if (rank_fin == idx) lo <= cand;
      if (rank_fin == idx + CW'(1)) hi <= cand;
    end
  end

  // hand-off to the interpolator
  assign n_ext       = XW'(n);
  assign sel.lo      = lo;
  assign sel.hi      = hi;
  assign sel.frac    = frac;
  assign sel.need_hi = (frac != 16'd0);
  assign sel.count   = n_ext[PQS_COUNT_W-1:0];

endmodule

FILE: rtl/core/pqs_interp.sv
// ----------------------------------------------------------------------------
// pqs_interp
// Linear blend of two order statistics with round-half-up, followed by the
// result output register.
// ----------------------------------------------------------------------------
module pqs_interp
  import pqs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     sel_valid,
  output logic     sel_ready,
  input  pqs_sel_t sel,
  pqs_out_if.source result_out
);

  logic                           s1_valid;
  logic signed [33:0]             s1_prod;
  logic signed [PQS_SAMPLE_W-1:0] s1_lo;
  logic        [PQS_COUNT_W-1:0]  s1_count;

  logic                           o_valid;
  logic signed [PQS_SAMPLE_W-1:0] o_value;
  logic        [PQS_COUNT_W-1:0]  o_count;

  logic                           o_free;
  logic signed [16:0]             diff;
  logic signed [33:0]             prod;
  logic        [34:0]             blend;

  // weighted difference, zero when the position is exact
  assign diff = sel.need_hi ? ({sel.hi[15], sel.hi} - {sel.lo[15], sel.lo}) : 17'sd0;
  assign prod = diff * $signed({1'b0, sel.frac});

  // lo * 65536 + weighted difference + one half, floor by the shift
  assign blend = {{3{s1_lo[15]}}, s1_lo, 16'h0000} + {s1_prod[33], s1_prod} + 35'd32768;

  // pipeline handshake
  assign o_free    = !o_valid || result_out.ready;
  assign sel_ready = !s1_valid || o_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (o_free) o_valid <= s1_valid;
      if (sel_ready) s1_valid <= sel_valid;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (o_free && s1_valid) begin
      o_value <= $signed(blend[31:16]);
      o_count <= s1_count;
    end
    if (sel_ready && sel_valid) begin
      s1_prod  <= prod;
      s1_lo    <= sel.lo;
      s1_count <= sel.count;
    end
  end

  assign result_out.valid          = o_valid;
  assign result_out.quantile_value = o_value;
  assign result_out.sample_count   = o_count;

endmodule

FILE: rtl/core/patch_quantile_select_top.sv
// ----------------------------------------------------------------------------
// patch_quantile_select_top
// Interpolated quantile of a patch of signed samples.
// ----------------------------------------------------------------------------
// Usage:
//   sample_in takes one sample per item; the item with last set closes the
//   patch. Samples beyond MAX_SAMPLES are dropped, the patch still closes.
//   result_out gives one item per patch: the quantile at quantile_fraction
//   (in 1/65536, written through cfg_we/cfg_wdata while idle) and the count.
// Throughput:
//   while loading, one item per cycle. After the closing item sample_in
//   drops ready until the result is handed off: every stored sample is
//   ranked by one full scan over the single read port of the store. The
//   hand-off is registered in the multiply stage and then in the rounding
//   stage, which drives result_out.
// Reset:
//   rst (synchronous) empties the patch and sets quantile_fraction to
//   one half; the store contents need no clearing.
// Stalls:
//   a held result does not block loading of the next patch; the end of a
//   patch waits in its final state only while both result stages are full.
// ----------------------------------------------------------------------------
module patch_quantile_select_top
  import pqs_pkg::*;
#(
  parameter int MAX_SAMPLES = PQS_MAX_SAMPLES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [PQS_FRAC_W-1:0] cfg_wdata,
  pqs_in_if.sink                sample_in,
  pqs_out_if.source             result_out
);

  localparam int AW = $clog2(MAX_SAMPLES);

  logic [PQS_FRAC_W-1:0]   quantile_fraction;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [PQS_SAMPLE_W-1:0] ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [PQS_SAMPLE_W-1:0] ram_rdata;
  logic                    sel_valid;
  logic                    sel_ready;
  pqs_sel_t                sel;

  // quantile fraction register
  always_ff @(posedge clk) begin
    if (rst) begin
      quantile_fraction <= PQS_QF_RESET;
    end else if (cfg_we) begin
      quantile_fraction <= cfg_wdata;
    end
  end

  // sample store
  pqs_ram #(
    .WIDTH (PQS_SAMPLE_W),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // load and rank selection
  pqs_ctrl #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .quantile_fraction (quantile_fraction),
    .sample_in         (sample_in),
    .ram_we            (ram_we),
    .ram_waddr         (ram_waddr),
    .ram_wdata         (ram_wdata),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata),
    .sel_valid         (sel_valid),
    .sel_ready         (sel_ready),
    .sel               (sel)
  );

  // blend, rounding and output register
  pqs_interp u_interp (
    .clk        (clk),
    .rst        (rst),
    .sel_valid  (sel_valid),
    .sel_ready  (sel_ready),
    .sel        (sel),
    .result_out (result_out)
  );

endmodule

FILE: bench/pqs_quantile_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqs_quantile_checker
// Watches the sample and result channels of the patch quantile select block,
// keeps its own copy of the patch and the quantile fraction, works out the
// interpolated quantile of every closed patch and compares each result item
// with the oldest outstanding one.
// ----------------------------------------------------------------------------
module pqs_quantile_checker
  import pqs_pkg::*;
#(
  parameter int MAX_SAMPLES = PQS_MAX_SAMPLES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic        [PQS_FRAC_W-1:0]   cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [PQS_SAMPLE_W-1:0] in_sample,
  input  logic                           in_last,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [PQS_SAMPLE_W-1:0] out_value,
  input  logic        [PQS_COUNT_W-1:0]  out_count,
  output int                             fail_count,
  output int                             pending
);

  typedef struct {
    logic signed [PQS_SAMPLE_W-1:0] value;
    logic        [PQS_COUNT_W-1:0]  count;
  } quantile_result_t;

  quantile_result_t               quantile_q[$];
  logic signed [PQS_SAMPLE_W-1:0] patch_buf [MAX_SAMPLES];
  int                             patch_len;
  logic        [PQS_FRAC_W-1:0]   fraction;

  // sort the held patch and blend the two order statistics around q*(n-1)
  function automatic quantile_result_t patch_quantile();
    logic signed [PQS_SAMPLE_W-1:0] ordered [MAX_SAMPLES];
    logic signed [PQS_SAMPLE_W-1:0] key;
    int                             j;
    int                             idx;
    longint                         q;
    longint                         pos;
    longint                         part;
    longint                         lo;
    longint                         hi;
    longint                         blend;
    longint                         rounded;
    quantile_result_t               r;
    for (int i = 0; i < patch_len; i++) ordered[i] = patch_buf[i];
    for (int i = 1; i < patch_len; i++) begin
      key = ordered[i];
      j   = i;
      while (j > 0 && ordered[j-1] > key) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = key;
    end
    // fractions above one saturate to the maximum
    q    = (fraction > PQS_FRAC_ONE) ? PQS_FRAC_ONE : fraction;
    pos  = q * (patch_len - 1);
    idx  = int'(pos >>> 16);
    part = pos & 64'hFFFF;
    if (idx >= patch_len) idx = patch_len - 1;
    lo = ordered[idx];
    if (part == 0 || idx + 1 >= patch_len) begin
      rounded = lo;
    end else begin
      hi    = ordered[idx+1];
      blend = lo * 65536 + (hi - lo) * part;
      // round half up, biased so the shift sees a non-negative value
      rounded = ((blend + 32768 + 64'sd2147483648) >>> 16) - 32768;
    end
    r.value = rounded[PQS_SAMPLE_W-1:0];
    r.count = patch_len[PQS_COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    quantile_result_t exp_r;
    if (rst) begin
      patch_len  = 0;
      fraction   = PQS_QF_RESET;
      fail_count = 0;
      quantile_q.delete();
    end else begin
      if (cfg_we) fraction = cfg_wdata;

      // result item against the oldest outstanding quantile
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        if (quantile_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result item with none outstanding: value %0d count %0d",
                     $realtime, out_value, out_count);
        end else begin
          exp_r = quantile_q.pop_front();
          if (out_value !== exp_r.value || out_count !== exp_r.count) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch: expected value %0d count %0d, got value %0d count %0d",
                       $realtime, exp_r.value, exp_r.count, out_value, out_count);
          end
        end
      end

      // sample item: store unless full, close the patch on last
      if (in_valid === 1'b1 && in_ready === 1'b1) begin
        if (patch_len < MAX_SAMPLES) begin
          patch_buf[patch_len] = in_sample;
          patch_len++;
        end
        if (in_last) begin
          quantile_q.push_back(patch_quantile());
          patch_len = 0;
        end
      end
    end
    pending = quantile_q.size();
  end

endmodule

FILE: bench/patch_quantile_select_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// patch_quantile_select_top_tb
// Drives patches of signed samples into the patch quantile select block with
// random gaps and result stalls, across several quantile fractions including
// the minimum, the maximum and saturated values; a checker beside the block
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module patch_quantile_select_top_tb;
  import pqs_pkg::*;

  localparam int MAX_SAMPLES = PQS_MAX_SAMPLES;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [PQS_FRAC_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;
  int                    item_total;
  bit                    calm;

  pqs_in_if  sample_if ();
  pqs_out_if result_if ();

  patch_quantile_select_top #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .sample_in  (sample_if),
    .result_out (result_if)
  );

  pqs_quantile_checker #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) quantile_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (sample_if.valid),
    .in_ready   (sample_if.ready),
    .in_sample  (sample_if.sample),
    .in_last    (sample_if.last),
    .out_valid  (result_if.valid),
    .out_ready  (result_if.ready),
    .out_value  (result_if.quantile_value),
    .out_count  (result_if.sample_count),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // run limit
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // one sample item, held until accepted
  task automatic send_sample(input logic signed [PQS_SAMPLE_W-1:0] s, input logic l);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      sample_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_if.valid  = 1'b1;
    sample_if.sample = s;
    sample_if.last   = l;
    @(posedge clk);
    while (sample_if.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    item_total++;
  endtask

  // random patch content, weighted toward extremes and ties
  task automatic send_patch(input int len);
    logic signed [PQS_SAMPLE_W-1:0] s;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 5))
        0:       s = -16'sd32768;
        1:       s = 16'sd32767;
        2:       s = PQS_SAMPLE_W'($signed($urandom_range(0, 8)) - 4);
        default: s = PQS_SAMPLE_W'($urandom);
      endcase
      send_sample(s, i == len - 1);
    end
  endtask

  // fraction write once the block has drained
  task automatic write_fraction(input logic [PQS_FRAC_W-1:0] v);
    sample_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // result side: random stall before each item
  initial begin
    int gap;
    result_if.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        result_if.ready = 1'b0;
        if ($urandom_range(0, 1)) begin
          @(posedge clk);
          while (result_if.valid !== 1'b1) @(posedge clk);
          @(negedge clk);
        end
        repeat (gap) @(negedge clk);
      end
      result_if.ready = 1'b1;
      @(posedge clk);
      while (result_if.valid !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    int budget;
    int phase;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    sample_if.valid  = 1'b0;
    sample_if.sample = '0;
    sample_if.last   = 1'b0;
    item_total       = 0;
    calm             = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // single-sample patches at the extremes, median after reset
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd32767, 1'b1);
    // halfway blends round up
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b1);
    // exact position gives the order statistic itself
    send_sample(16'sd5, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b1);
    // widest difference between neighbors
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b1);

    // minimum, maximum, saturated and smallest nonzero fraction
    write_fraction('0);
    send_sample(16'sd3, 1'b0);
    send_sample(-16'sd7, 1'b0);
    send_sample(16'sd9, 1'b1);
    write_fraction(PQS_FRAC_ONE);
    send_sample(16'sd3, 1'b0);
    send_sample(-16'sd7, 1'b0);
    send_sample(16'sd9, 1'b1);
    write_fraction('1);
    send_sample(16'sd3, 1'b0);
    send_sample(-16'sd7, 1'b0);
    send_sample(16'sd9, 1'b1);
    write_fraction(17'd1);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b1);

    // random phases, each under its own fraction
    phase = 0;
    while (item_total < 460) begin
      case ($urandom_range(0, 6))
        0:       write_fraction('0);
        1:       write_fraction(PQS_FRAC_ONE);
        2:       write_fraction(PQS_FRAC_W'($urandom_range(65537, 131071)));
        3:       write_fraction(17'd65535);
        4:       write_fraction(PQS_QF_RESET);
        default: write_fraction(PQS_FRAC_W'($urandom_range(0, 65536)));
      endcase
      calm   = ($urandom_range(0, 3) == 0);
      budget = $urandom_range(40, 70);
      // a patch at or near a full store, sometimes with dropped samples past it
      if (phase % 3 == 1) begin
        send_patch(phase == 1 ? MAX_SAMPLES : $urandom_range(MAX_SAMPLES - 4, MAX_SAMPLES + 6));
      end
      while (budget > 0) begin
        int len;
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        send_patch(len);
        budget -= len;
      end
      phase++;
    end

    // drain and verdict
    sample_if.valid = 1'b0;
    calm            = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
